FILE: rtl/core/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types, byte codes and small helper functions for the framed packet
// receiver with CRC-16 check.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

	// Sync pair and device bytes on the serial line.
	localparam logic [7:0] SYNC_FIRST  = 8'hFF;
	localparam logic [7:0] SYNC_SECOND = 8'hCC;
	localparam logic [7:0] DEV_BYTE_BASE  = 8'h0B;
	localparam logic [7:0] DEV_BYTE_LINK1 = 8'h0C;
	localparam logic [7:0] DEV_BYTE_LINK2 = 8'h0D;

	// Shortest legal frames, counted in bytes including the sync pair.
	localparam int MIN_LEN_BASIC = 5;
	localparam int MIN_LEN_LINK2 = 6;

	// Configuration register indexes.
	localparam logic [1:0] CFG_BASE_LEN  = 2'd0;
	localparam logic [1:0] CFG_LINK1_LEN = 2'd1;
	localparam logic [1:0] CFG_LINK2_LEN = 2'd2;

	// CRC-16/XMODEM polynomial.
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Velocity command limits.
	localparam logic [7:0] CMD_LIMIT  = 8'd200;
	localparam logic [7:0] CMD_OFFSET = 8'd100;

	// Sender of a frame.
	typedef enum logic [1:0] {
		DEV_BASE  = 2'd0,
		DEV_LINK1 = 2'd1,
		DEV_LINK2 = 2'd2
	} dev_t;

	// One completed frame report.
	typedef struct packed {
		dev_t               frame_device;
		logic               crc_match;
		logic [15:0]        received_crc;
		logic signed [7:0]  shoulder_command;
		logic signed [7:0]  elbow_command;
	} result_t;

	// Feed one byte into a CRC-16/XMODEM register, MSB first.
	function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Turn a raw command byte into a signed velocity: values over the limit
	// are forced to the offset, then the offset is removed.
	function automatic logic signed [7:0] cmd_of(input logic [7:0] v);
		logic [7:0] c;
		c = (v > CMD_LIMIT) ? CMD_OFFSET : v;
		return $signed(c - CMD_OFFSET);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fpr_cfg_regs.sv
// ----------------------------------------------------------------------------
// fpr_cfg_regs
// Frame length registers with their write port; presents each length clamped
// to the legal range for its device.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_cfg_regs #(
	parameter int MAX_FRAME = 16,
	localparam int LW = $clog2(MAX_FRAME + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [4:0]    cfg_data,
	output logic [LW-1:0]      len_base,
	output logic [LW-1:0]      len_link1,
	output logic [LW-1:0]      len_link2
);
	import fpr_pkg::*;

	logic [4:0] base_len_q;
	logic [4:0] link1_len_q;
	logic [4:0] link2_len_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;

	// Register file; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_len_q  <= 5'd9;
			link1_len_q <= 5'd5;
			link2_len_q <= 5'd10;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BASE_LEN:  base_len_q  <= cfg_data;
				CFG_LINK1_LEN: link1_len_q <= cfg_data;
				CFG_LINK2_LEN: link2_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp a stored length into [lo, MAX_FRAME].
	function automatic logic [LW-1:0] clamp_len(input logic [4:0] v, input int lo);
		logic [LW-1:0] r;
		if (int'(v) < lo) begin
			r = LW'(lo);
		end else if (int'(v) > MAX_FRAME) begin
			r = LW'(MAX_FRAME);
		end else begin
			r = LW'(v);
		end
		return r;
	endfunction

	assign len_base  = clamp_len(base_len_q, MIN_LEN_BASIC);
	assign len_link1 = clamp_len(link1_len_q, MIN_LEN_BASIC);
	assign len_link2 = clamp_len(link2_len_q, MIN_LEN_LINK2);

endmodule

`default_nettype wire

FILE: rtl/core/fpr_parser.sv
// ----------------------------------------------------------------------------
// fpr_parser
// Input register and frame parser: sync hunt, device decode, CRC update over
// the frame body and assembly of the frame report on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_parser #(
	parameter int MAX_FRAME = 16,
	localparam int LW = $clog2(MAX_FRAME + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,
	input  wire logic [LW-1:0]     len_base,
	input  wire logic [LW-1:0]     len_link1,
	input  wire logic [LW-1:0]     len_link2,
	input  wire logic              out_free,
	output logic                   res_load,
	output fpr_pkg::result_t       res
);
	import fpr_pkg::*;

	localparam int PW = $clog2(MAX_FRAME);

	typedef enum logic [3:0] {
		ST_HUNT   = 4'b0001,
		ST_SYNC2  = 4'b0010,
		ST_DEVICE = 4'b0100,
		ST_BODY   = 4'b1000
	} state_t;

	// Input register.
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// Frame state.
	state_t         state_q, state_d;
	logic [PW-1:0]  pos_q, pos_d;
	logic [LW-1:0]  len_q, len_d;
	dev_t           sender_q, sender_d;
	logic [15:0]    crc_q, crc_d;
	logic [7:0]     tail0_q, tail0_d;
	logic [7:0]     tail1_q, tail1_d;
	logic [7:0]     sh_q, sh_d;
	logic [7:0]     el_q, el_d;

	logic emit;
	logic fire;
	logic last_byte;

	// The held byte moves on unless it closes a frame while the result
	// register is occupied and not being drained.
	assign last_byte = (state_q == ST_BODY) && ((LW'(pos_q) + LW'(1)) >= len_q);
	assign emit      = valid_s1 && last_byte;
	assign fire      = valid_s1 && (!last_byte || out_free);
	assign s_tready  = !valid_s1 || fire;
	assign res_load  = emit && fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// Next frame state for the held byte.
	always_comb begin
		state_d  = state_q;
		pos_d    = pos_q;
		len_d    = len_q;
		sender_d = sender_q;
		crc_d    = crc_q;
		tail0_d  = tail0_q;
		tail1_d  = tail1_q;
		sh_d     = sh_q;
		el_d     = el_q;
		case (state_q)
			ST_HUNT: begin
				if (byte_s1 == SYNC_FIRST) begin
					state_d = ST_SYNC2;
				end
			end
			ST_SYNC2: begin
				if (byte_s1 == SYNC_SECOND) begin
					state_d = ST_DEVICE;
				end else if (byte_s1 != SYNC_FIRST) begin
					state_d = ST_HUNT;
				end
			end
			ST_DEVICE: begin
				state_d = ST_BODY;
				case (byte_s1)
					DEV_BYTE_BASE: begin
						sender_d = DEV_BASE;
						len_d    = len_base;
					end
					DEV_BYTE_LINK1: begin
						sender_d = DEV_LINK1;
						len_d    = len_link1;
					end
					DEV_BYTE_LINK2: begin
						sender_d = DEV_LINK2;
						len_d    = len_link2;
					end
					default: begin
						state_d = ST_HUNT;
					end
				endcase
				crc_d   = '0;
				tail0_d = '0;
				tail1_d = byte_s1;
				sh_d    = '0;
				el_d    = '0;
				pos_d   = PW'(3);
			end
			ST_BODY: begin
				// The last two bytes are held back since they may be the CRC.
				if (pos_q >= PW'(4)) begin
					crc_d = crc16_feed(crc_q, tail0_q);
				end
				tail0_d = tail1_q;
				tail1_d = byte_s1;
				if (pos_q == PW'(4)) begin
					sh_d = byte_s1;
				end
				if (pos_q == PW'(5)) begin
					el_d = byte_s1;
				end
				if (last_byte) begin
					state_d = ST_HUNT;
				end else begin
					pos_d = pos_q + PW'(1);
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	// Frame report, valid when the held byte closes the frame.
	always_comb begin
		res.frame_device = sender_q;
		res.received_crc = {tail1_q, byte_s1};
		res.crc_match    = ({tail1_q, byte_s1} == crc_d);
		if (sender_q == DEV_LINK2) begin
			res.shoulder_command = cmd_of(sh_d);
			res.elbow_command    = cmd_of(el_d);
		end else begin
			res.shoulder_command = '0;
			res.elbow_command    = '0;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else if (fire) begin
			state_q <= state_d;
		end
	end

	// Frame payload state.
	always_ff @(posedge clk) begin
		if (fire) begin
			pos_q    <= pos_d;
			len_q    <= len_d;
			sender_q <= sender_d;
			crc_q    <= crc_d;
			tail0_q  <= tail0_d;
			tail1_q  <= tail1_d;
			sh_q     <= sh_d;
			el_q     <= el_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/fpr_out_reg.sv
// ----------------------------------------------------------------------------
// fpr_out_reg
// Result register for the frame reports, packed onto the master-side stream.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              res_load,
	input  wire fpr_pkg::result_t  res,
	output logic                   out_free,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [31:0]            m_tdata,
	output logic [2:0]             m_tuser
);
	import fpr_pkg::*;

	result_t res_q;
	logic    valid_q;

	// The register can take a new item when empty or being drained.
	assign out_free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	// Pack the stream fields.
	assign m_tvalid = valid_q;
	assign m_tdata  = {res_q.elbow_command, res_q.shoulder_command, res_q.received_crc};
	assign m_tuser  = {res_q.crc_match, res_q.frame_device};

endmodule

`default_nettype wire

FILE: rtl/core/framed_packet_receiver_crc16.sv
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc16
// Receives a byte stream, finds 0xFF 0xCC framed packets, checks their
// CRC-16/XMODEM and reports each completed frame.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while its input side is not stalled. A
// byte goes into an input register, the parser updates its frame state and CRC
// from it, and the report of a frame's last byte is loaded into the result
// register, from which it shows on the master side. The input side stalls only
// when that last byte finds the result register still full and not drained.
// Frame lengths are taken from the length registers when the device byte
// arrives, clamped to at least five bytes (six for link2) and at most MAX_FRAME.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_packet_receiver_crc16 #(
	parameter int MAX_FRAME = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Received bytes.
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
	// Frame reports.
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [31:0]       m_tdata,   // [15:0] received_crc, [23:16] shoulder_command,
	                                     // [31:24] elbow_command
	output logic [2:0]        m_tuser,   // [1:0] frame_device, [2] crc_match
	// Length register writes.
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [4:0]   cfg_data
);
	import fpr_pkg::*;

	localparam int LW = $clog2(MAX_FRAME + 1);

	logic [LW-1:0] len_base;
	logic [LW-1:0] len_link1;
	logic [LW-1:0] len_link2;
	logic          out_free;
	logic          res_load;
	result_t       res;

	fpr_cfg_regs #(.MAX_FRAME(MAX_FRAME)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.len_base  (len_base),
		.len_link1 (len_link1),
		.len_link2 (len_link2)
	);

	fpr_parser #(.MAX_FRAME(MAX_FRAME)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.len_base  (len_base),
		.len_link1 (len_link1),
		.len_link2 (len_link2),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res)
	);

	fpr_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_load (res_load),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

FILE: rtl/core/fpr_checker.sv
// ----------------------------------------------------------------------------
// fpr_checker
// Port-level checks for the framed packet receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [31:0]  m_tdata,
	input wire logic [2:0]   m_tuser
);
	import fpr_pkg::*;

	// A report that is not taken stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("report dropped while stalled");

	// A report that is not taken keeps its contents.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("report changed while stalled");

	// Only the three known senders are reported.
	a_device: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[1:0] == DEV_BASE) || (m_tuser[1:0] == DEV_LINK1)
			|| (m_tuser[1:0] == DEV_LINK2))
		else $error("unknown sender reported");

	// Base and link1 frames carry no commands.
	a_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != DEV_LINK2) |-> (m_tdata[31:16] == 16'h0000))
		else $error("commands on a frame without them");

	// Link2 commands stay within plus or minus 100.
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == DEV_LINK2) |->
			($signed(m_tdata[23:16]) >= -8'sd100) && ($signed(m_tdata[23:16]) <= 8'sd100)
			&& ($signed(m_tdata[31:24]) >= -8'sd100) && ($signed(m_tdata[31:24]) <= 8'sd100))
		else $error("command out of range");

endmodule

bind framed_packet_receiver_crc16 fpr_checker u_fpr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
